// File: sv/bbe_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// bbe_pkg
// Shared widths, types, codes and helpers of the B-spline basis evaluator.
// ============================================================================
package bbe_pkg;

    localparam int FRAC_BITS = 16;
    localparam int UW        = 24;             // parameter u, 8.16
    localparam int IW        = 9;              // basis index
    localparam int KW        = 8;              // knot value
    localparam int OW        = 3;              // curve order
    localparam int FW        = 16;             // fuzz threshold
    localparam int VW        = 17;             // basis value, Q1.16
    localparam int SW        = 19;             // basis slope, Q3.16
    localparam int EW        = UW + 2;         // signed distance u - knot
    localparam int AW        = 18;             // value factor
    localparam int BW        = 20;             // slope factor, signed
    localparam int ABW       = 2 * AW;         // first value product
    localparam int NVW       = ABW + AW;       // value numerator, 2^-48 units
    localparam int PSW       = 2 * BW;         // slope partial product
    localparam int NSW       = PSW + 1;        // slope numerator, 2^-32 units
    localparam int MVW       = NVW + 2;
    localparam int MSW       = NSW + 2;
    localparam int YVW       = MVW - (2 * FRAC_BITS + 1);
    localparam int YSW       = MSW - (FRAC_BITS + 1);
    localparam int XW        = 25;             // dividend of the divide by 3
    localparam int QW        = 24;             // rounded term magnitude
    localparam int PW        = 2 * XW;
    localparam int DIV3_SH   = 26;
    localparam logic [XW-1:0] DIV3_MAGIC = 25'd22369622;  // ceil(2^26 / 3)

    localparam logic [VW-1:0] VAL_MAX = VW'(1 << FRAC_BITS);
    localparam logic signed [SW:0] SLOPE_MIN = -(SW+1)'(1 << (SW - 1));
    localparam logic signed [SW:0] SLOPE_MAX = (SW+1)'((1 << (SW - 1)) - 1);

    // curve orders
    localparam logic [OW-1:0] ORD_LIN   = 3'd2;
    localparam logic [OW-1:0] ORD_QUAD  = 3'd3;
    localparam logic [OW-1:0] ORD_CUBIC = 3'd4;

    // register indexes
    localparam logic [1:0] REG_ORDER = 2'd0;
    localparam logic [1:0] REG_MAXK  = 2'd1;
    localparam logic [1:0] REG_FUZZ  = 2'd2;

    typedef logic [AW-1:0]         t_vf;
    typedef logic signed [BW-1:0]  t_sf;
    typedef logic [ABW-1:0]        t_ab;
    typedef logic signed [PSW-1:0] t_ps;
    typedef logic [NVW-1:0]        t_nv;
    typedef logic signed [NSW-1:0] t_ns;
    typedef logic [XW-1:0]         t_x;
    typedef logic [QW-1:0]         t_q;

    // denominator = 2^k * (m3 ? 3 : 1)
    typedef struct packed {
        logic [1:0] k;
        logic       m3;
    } t_den;

    localparam t_den DEN_ONE = '{k: 2'd0, m3: 1'b0};

    typedef struct packed {
        t_den [2:0]    den;
        logic [FW-1:0] fuzz;
        logic          is2;
        logic          is3;
    } t_ctl;

    function automatic t_den den3(input logic [2:0] a, input logic [2:0] b,
                                  input logic [2:0] c);
        logic [8:0] p;
        t_den       d;
        p = {6'b0, a} * {6'b0, b} * {6'b0, c};
        case (p)
            9'd2:    d = '{k: 2'd1, m3: 1'b0};
            9'd3:    d = '{k: 2'd0, m3: 1'b1};
            9'd4:    d = '{k: 2'd2, m3: 1'b0};
            9'd6:    d = '{k: 2'd1, m3: 1'b1};
            default: d = DEN_ONE;
        endcase
        return d;
    endfunction

endpackage

// File: sv/bbe_front.sv
`timescale 1ns / 1ps
// ============================================================================
// bbe_front
// Stage 1: clamp u, build knots, pick the span, select the term factors.
// ============================================================================
module bbe_front (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [bbe_pkg::UW-1:0] i_u,
    input  logic [bbe_pkg::IW-1:0] i_idx,
    input  logic [bbe_pkg::OW-1:0] i_order,
    input  logic [bbe_pkg::KW-1:0] i_max_knot,
    input  logic [bbe_pkg::FW-1:0] i_fuzz,
    output bbe_pkg::t_vf           o_va [3],
    output bbe_pkg::t_vf           o_vb [3],
    output bbe_pkg::t_vf           o_vc [3],
    output bbe_pkg::t_sf           o_sa1 [3],
    output bbe_pkg::t_sf           o_sb1 [3],
    output bbe_pkg::t_sf           o_sa2 [3],
    output bbe_pkg::t_sf           o_sb2 [3],
    output bbe_pkg::t_ctl          o_ctl
);
    import bbe_pkg::*;

    localparam t_vf VONE = AW'(1 << FRAC_BITS);
    localparam t_sf SONE = BW'(1 << FRAC_BITS);

    logic [UW-1:0]            umax, uc;
    logic signed [IW+1:0]     kidx [5];
    logic [KW-1:0]            t [5];
    logic signed [EW-1:0]     e [5];
    logic signed [EW-1:0]     f [5];
    logic [3:0]               ok;
    logic                     found;
    logic [1:0]               span;
    logic [2:0]               d10, d20, d21, d30, d31, d32, d41, d42, d43;
    t_vf  n_va [3], n_vb [3], n_vc [3];
    t_sf  n_sa1 [3], n_sb1 [3], n_sa2 [3], n_sb2 [3];
    t_ctl n_ctl;
    t_vf  r_va [3], r_vb [3], r_vc [3];
    t_sf  r_sa1 [3], r_sb1 [3], r_sa2 [3], r_sb2 [3];
    t_ctl r_ctl;

    function automatic t_vf to_v(input logic signed [EW-1:0] x);
        return x[AW-1:0];
    endfunction

    function automatic t_sf to_s(input logic signed [EW-1:0] x);
        return x[BW-1:0];
    endfunction

    assign umax = {i_max_knot, {FRAC_BITS{1'b0}}};
    assign uc   = (i_u > umax) ? umax : i_u;

    always_comb begin
        for (int j = 0; j < 5; j++) begin
            kidx[j] = $signed({2'b00, i_idx}) - $signed({8'b0, i_order})
                    + $signed((IW+2)'(j));
            if (kidx[j] < 0) begin
                t[j] = '0;
            end else if (kidx[j] > $signed({3'b0, i_max_knot})) begin
                t[j] = i_max_knot;
            end else begin
                t[j] = kidx[j][KW-1:0];
            end
            e[j] = $signed({2'b00, uc}) - $signed({2'b00, t[j], {FRAC_BITS{1'b0}}});
            f[j] = -e[j];
        end
    end

    // first nonempty span with t[j] <= u <= t[j+1]
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            ok[j] = (uc[UW-1:FRAC_BITS] >= t[j])
                 && ((uc[UW-1:FRAC_BITS] < t[j+1])
                     || (uc[UW-1:FRAC_BITS] == t[j+1] && uc[FRAC_BITS-1:0] == '0))
                 && (t[j] != t[j+1])
                 && (OW'(j) < i_order);
        end
        found = 1'b0;
        span  = 2'd0;
        for (int j = 3; j >= 0; j--) begin
            if (ok[j]) begin
                found = 1'b1;
                span  = 2'(j);
            end
        end
    end

    assign d10 = 3'(t[1] - t[0]);
    assign d20 = 3'(t[2] - t[0]);
    assign d21 = 3'(t[2] - t[1]);
    assign d30 = 3'(t[3] - t[0]);
    assign d31 = 3'(t[3] - t[1]);
    assign d32 = 3'(t[3] - t[2]);
    assign d41 = 3'(t[4] - t[1]);
    assign d42 = 3'(t[4] - t[2]);
    assign d43 = 3'(t[4] - t[3]);

    always_comb begin
        n_va  = '{default: '0};
        n_vb  = '{default: '0};
        n_vc  = '{default: '0};
        n_sa1 = '{default: '0};
        n_sb1 = '{default: '0};
        n_sa2 = '{default: '0};
        n_sb2 = '{default: '0};
        n_ctl.den  = {DEN_ONE, DEN_ONE, DEN_ONE};
        n_ctl.fuzz = i_fuzz;
        n_ctl.is2  = (i_order == ORD_LIN);
        n_ctl.is3  = (i_order == ORD_QUAD);
        if (found) begin
            case (i_order)
                ORD_CUBIC: begin
                    case (span)
                        2'd0: begin
                            n_ctl.den[0] = den3(d30, d20, d10);
                            n_va[0] = to_v(e[0]); n_vb[0] = to_v(e[0]);
                            n_vc[0] = to_v(e[0]);
                            n_sa1[0] = to_s(e[0]);
                            n_sb1[0] = to_s((e[0] <<< 1) + e[0]);
                        end
                        2'd1: begin
                            n_ctl.den[0] = den3(d30, d20, d21);
                            n_ctl.den[1] = den3(d30, d31, d21);
                            n_ctl.den[2] = den3(d41, d31, d21);
                            n_va[0] = to_v(e[0]); n_vb[0] = to_v(e[0]);
                            n_vc[0] = to_v(f[2]);
                            n_va[1] = to_v(e[0]); n_vb[1] = to_v(f[3]);
                            n_vc[1] = to_v(e[1]);
                            n_va[2] = to_v(f[4]); n_vb[2] = to_v(e[1]);
                            n_vc[2] = to_v(e[1]);
                            n_sa1[0] = to_s(e[0]);
                            n_sb1[0] = to_s((f[2] <<< 1) - e[0]);
                            n_sa1[1] = to_s(e[0]);
                            n_sb1[1] = to_s(f[3] - e[1]);
                            n_sa2[1] = to_s(f[3]);
                            n_sb2[1] = to_s(e[1]);
                            n_sa1[2] = to_s(e[1]);
                            n_sb1[2] = to_s((f[4] <<< 1) - e[1]);
                        end
                        2'd2: begin
                            n_ctl.den[0] = den3(d30, d31, d32);
                            n_ctl.den[1] = den3(d41, d31, d32);
                            n_ctl.den[2] = den3(d41, d42, d32);
                            n_va[0] = to_v(e[0]); n_vb[0] = to_v(f[3]);
                            n_vc[0] = to_v(f[3]);
                            n_va[1] = to_v(f[4]); n_vb[1] = to_v(e[1]);
                            n_vc[1] = to_v(f[3]);
                            n_va[2] = to_v(f[4]); n_vb[2] = to_v(f[4]);
                            n_vc[2] = to_v(e[2]);
                            n_sa1[0] = to_s(f[3]);
                            n_sb1[0] = to_s(f[3] - (e[0] <<< 1));
                            n_sa1[1] = to_s(f[4]);
                            n_sb1[1] = to_s(f[3] - e[1]);
                            n_sa2[1] = to_s(f[1]);
                            n_sb2[1] = to_s(f[3]);
                            n_sa1[2] = to_s(f[4]);
                            n_sb1[2] = to_s(f[4] - (e[2] <<< 1));
                        end
                        default: begin
                            n_ctl.den[0] = den3(d41, d42, d43);
                            n_va[0] = to_v(f[4]); n_vb[0] = to_v(f[4]);
                            n_vc[0] = to_v(f[4]);
                            n_sa1[0] = to_s(f[4]);
                            n_sb1[0] = to_s(-((f[4] <<< 1) + f[4]));
                        end
                    endcase
                end
                ORD_QUAD: begin
                    n_vc  = '{VONE, VONE, VONE};
                    n_sb1 = '{SONE, SONE, SONE};
                    case (span)
                        2'd0: begin
                            n_ctl.den[0] = den3(d20, d10, 3'd1);
                            n_va[0] = to_v(e[0]); n_vb[0] = to_v(e[0]);
                            n_sa1[0] = to_s(e[0] <<< 1);
                        end
                        2'd1: begin
                            n_ctl.den[0] = den3(d20, d21, 3'd1);
                            n_ctl.den[1] = den3(d31, d21, 3'd1);
                            n_va[0] = to_v(e[0]); n_vb[0] = to_v(f[2]);
                            n_va[1] = to_v(f[3]); n_vb[1] = to_v(e[1]);
                            n_sa1[0] = to_s(f[2] - e[0]);
                            n_sa1[1] = to_s(f[3] - e[1]);
                        end
                        2'd2: begin
                            n_ctl.den[0] = den3(d31, d32, 3'd1);
                            n_va[0] = to_v(f[3]); n_vb[0] = to_v(f[3]);
                            n_sa1[0] = to_s(-(f[3] <<< 1));
                        end
                        default: ;
                    endcase
                end
                ORD_LIN: begin
                    n_vb[0]  = VONE;
                    n_vc[0]  = VONE;
                    n_sb1[0] = SONE;
                    case (span)
                        2'd0: begin
                            n_ctl.den[0] = den3(d10, 3'd1, 3'd1);
                            n_va[0]  = to_v(e[0]);
                            n_sa1[0] = SONE;
                        end
                        2'd1: begin
                            n_ctl.den[0] = den3(d21, 3'd1, 3'd1);
                            n_va[0]  = to_v(f[2]);
                            n_sa1[0] = -SONE;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_va  <= n_va;
            r_vb  <= n_vb;
            r_vc  <= n_vc;
            r_sa1 <= n_sa1;
            r_sb1 <= n_sb1;
            r_sa2 <= n_sa2;
            r_sb2 <= n_sb2;
            r_ctl <= n_ctl;
        end
    end

    assign o_va  = r_va;
    assign o_vb  = r_vb;
    assign o_vc  = r_vc;
    assign o_sa1 = r_sa1;
    assign o_sb1 = r_sb1;
    assign o_sa2 = r_sa2;
    assign o_sb2 = r_sb2;
    assign o_ctl = r_ctl;

endmodule

// File: sv/bbe_mul.sv
`timescale 1ns / 1ps
// ============================================================================
// bbe_mul
// Stages 2 and 3: term numerators from the selected factors.
// ============================================================================
module bbe_mul (
    input  logic           i_clk,
    input  logic           i_en2,
    input  logic           i_en3,
    input  bbe_pkg::t_vf   i_va [3],
    input  bbe_pkg::t_vf   i_vb [3],
    input  bbe_pkg::t_vf   i_vc [3],
    input  bbe_pkg::t_sf   i_sa1 [3],
    input  bbe_pkg::t_sf   i_sb1 [3],
    input  bbe_pkg::t_sf   i_sa2 [3],
    input  bbe_pkg::t_sf   i_sb2 [3],
    input  bbe_pkg::t_ctl  i_ctl,
    output bbe_pkg::t_nv   o_nv [3],
    output bbe_pkg::t_ns   o_ns [3],
    output bbe_pkg::t_ctl  o_ctl
);
    import bbe_pkg::*;

    t_ab  r_ab [3];
    t_vf  r_c [3];
    t_ps  r_p1 [3], r_p2 [3];
    t_ctl r_ctl2;
    t_nv  r_nv [3];
    t_ns  r_ns [3];
    t_ctl r_ctl3;

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            for (int i = 0; i < 3; i++) begin
                r_ab[i] <= ABW'(i_va[i]) * ABW'(i_vb[i]);
                r_c[i]  <= i_vc[i];
                r_p1[i] <= PSW'(i_sa1[i]) * PSW'(i_sb1[i]);
                r_p2[i] <= PSW'(i_sa2[i]) * PSW'(i_sb2[i]);
            end
            r_ctl2 <= i_ctl;
        end
        if (i_en3) begin
            for (int i = 0; i < 3; i++) begin
                r_nv[i] <= NVW'(r_ab[i]) * NVW'(r_c[i]);
                r_ns[i] <= NSW'(r_p1[i]) + NSW'(r_p2[i]);
            end
            r_ctl3 <= r_ctl2;
        end
    end

    assign o_nv  = r_nv;
    assign o_ns  = r_ns;
    assign o_ctl = r_ctl3;

endmodule

// File: sv/bbe_round.sv
`timescale 1ns / 1ps
// ============================================================================
// bbe_round
// Stages 4 and 5: fuzz, round to nearest and divide by the knot product.
// ============================================================================
module bbe_round (
    input  logic           i_clk,
    input  logic           i_en4,
    input  logic           i_en5,
    input  bbe_pkg::t_nv   i_nv [3],
    input  bbe_pkg::t_ns   i_ns [3],
    input  bbe_pkg::t_ctl  i_ctl,
    output bbe_pkg::t_q    o_qv [3],
    output bbe_pkg::t_q    o_qs [3],
    output logic           o_neg [3]
);
    import bbe_pkg::*;

    t_nv              thr_v;
    logic [NSW-1:0]   thr_s;
    logic [1:0]       dfac [3];
    logic [MVW-1:0]   mv [3];
    logic [YVW-1:0]   yv [3];
    logic [NSW-1:0]   mag [3];
    logic [MSW-1:0]   ms [3];
    logic [YSW-1:0]   ys [3];
    t_x               n_xv [3], n_xs [3];
    t_x               r_xv [3], r_xs [3];
    logic             r_m3 [3], r_neg4 [3];
    logic [PW-1:0]    pv [3], ps [3];
    t_q               r_qv [3], r_qs [3];
    logic             r_neg5 [3];

    // fuzz limits moved to each numerator's own scale
    always_comb begin
        if (i_ctl.is2) begin
            thr_v = t_nv'(i_ctl.fuzz) << (2 * FRAC_BITS);
        end else if (i_ctl.is3) begin
            thr_v = t_nv'(i_ctl.fuzz) << FRAC_BITS;
        end else begin
            thr_v = t_nv'(i_ctl.fuzz);
        end
        thr_s = i_ctl.is3 ? (NSW'(i_ctl.fuzz) << FRAC_BITS) : NSW'(i_ctl.fuzz);
    end

    // round half up: floor(floor((2N + D) / 2^(s+1)) / den)
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dfac[i] = i_ctl.den[i].m3 ? 2'd3 : 2'd1;
            mv[i] = {1'b0, i_nv[i], 1'b0}
                  + (MVW'(dfac[i]) << (2 * FRAC_BITS + int'(i_ctl.den[i].k)));
            yv[i] = mv[i][MVW-1:2*FRAC_BITS+1];
            n_xv[i] = (i_nv[i] < thr_v) ? '0 : XW'(yv[i] >> i_ctl.den[i].k);
            mag[i] = i_ns[i][NSW-1] ? NSW'(-i_ns[i]) : NSW'(i_ns[i]);
            ms[i] = {1'b0, mag[i], 1'b0}
                  + (MSW'(dfac[i]) << (FRAC_BITS + int'(i_ctl.den[i].k)));
            ys[i] = ms[i][MSW-1:FRAC_BITS+1];
            n_xs[i] = (!i_ctl.is2 && mag[i] < thr_s) ? '0 : XW'(ys[i] >> i_ctl.den[i].k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en4) begin
            for (int i = 0; i < 3; i++) begin
                r_xv[i]   <= n_xv[i];
                r_xs[i]   <= n_xs[i];
                r_m3[i]   <= i_ctl.den[i].m3;
                r_neg4[i] <= i_ns[i][NSW-1];
            end
        end
        if (i_en5) begin
            for (int i = 0; i < 3; i++) begin
                r_qv[i]   <= r_m3[i] ? QW'(pv[i] >> DIV3_SH) : QW'(r_xv[i]);
                r_qs[i]   <= r_m3[i] ? QW'(ps[i] >> DIV3_SH) : QW'(r_xs[i]);
                r_neg5[i] <= r_neg4[i];
            end
        end
    end

    // divide by 3 through the reciprocal
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pv[i] = PW'(r_xv[i]) * PW'(DIV3_MAGIC);
            ps[i] = PW'(r_xs[i]) * PW'(DIV3_MAGIC);
        end
    end

    assign o_qv  = r_qv;
    assign o_qs  = r_qs;
    assign o_neg = r_neg5;

endmodule

// File: sv/bspline_basis_eval_top.sv
`timescale 1ns / 1ps
// ============================================================================
// bspline_basis_eval_top
// B-spline basis value and first derivative, order 2..4, clamped knots.
// ============================================================================
// Usage:
//   Input channel : i_valid / o_stall carry a request (i_param_u, u in 8.16,
//                   and i_span_index). A request is taken at a clock edge
//                   with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall carry o_basis_value (Q1.16) and
//                   o_basis_slope (signed Q3.16), one result per request,
//                   in request order.
//   Config port   : APB-style; curve_order at 0x0, max_knot at 0x4,
//                   fuzz_threshold at 0x8. Write only while idle.
//   Pipeline      : the accepting edge loads the front end; the request then
//                   moves through the multiplier stages, round, divide by 3
//                   and the sum and saturate register, which drives o_valid.
//   Throughput    : one request per cycle while o_stall is low.
//   Stall         : each stage advances when its successor is empty or
//                   moving, so bubbles close up behind a stalled result;
//                   o_stall rises only when all six stages hold requests.
//   Reset         : synchronous, active low; empties the pipe and loads
//                   order 4, max_knot 1, fuzz 0.
// ============================================================================
module bspline_basis_eval_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [bbe_pkg::UW-1:0]       i_param_u,
    input  logic [bbe_pkg::IW-1:0]       i_span_index,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [bbe_pkg::VW-1:0]       o_basis_value,
    output logic signed [bbe_pkg::SW-1:0] o_basis_slope,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [3:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import bbe_pkg::*;

    localparam int NST  = 6;
    localparam int SUMW = QW + 2;
    localparam int SSW  = QW + 3;

    // configuration registers
    logic [OW-1:0] r_curve_order;
    logic [KW-1:0] r_max_knot;
    logic [FW-1:0] r_fuzz;
    logic          cfg_wr;
    logic [1:0]    cfg_idx;

    // pipeline control: one valid bit per stage, stage 6 is the output
    logic [NST-1:0] r_vld;
    logic [NST-1:0] en;

    t_vf  s1_va [3], s1_vb [3], s1_vc [3];
    t_sf  s1_sa1 [3], s1_sb1 [3], s1_sa2 [3], s1_sb2 [3];
    t_ctl s1_ctl, s3_ctl;
    t_nv  s3_nv [3];
    t_ns  s3_ns [3];
    t_q   s5_qv [3], s5_qs [3];
    logic s5_neg [3];

    logic [SUMW-1:0]       sum_v;
    logic signed [SSW-1:0] sum_s;
    logic [VW-1:0]         n_val;
    logic signed [SW-1:0]  n_slope;
    logic [VW-1:0]         r_val;
    logic signed [SW-1:0]  r_slope;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_order <= ORD_CUBIC;
            r_max_knot    <= KW'(1);
            r_fuzz        <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ORDER: r_curve_order <= pwdata[OW-1:0];
                REG_MAXK:  r_max_knot    <= pwdata[KW-1:0];
                REG_FUZZ:  r_fuzz        <= pwdata[FW-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ORDER: prdata = 32'(r_curve_order);
            REG_MAXK:  prdata = 32'(r_max_knot);
            REG_FUZZ:  prdata = 32'(r_fuzz);
            default:   prdata = '0;
        endcase
    end

    // ---------------- pipeline flow control ----------------
    // A stage loads when it is empty or its successor loads too.
    always_comb begin
        en[NST-1] = !r_vld[NST-1] || !i_stall;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[NST-1];

    // ---------------- datapath ----------------
    bbe_front u_front (
        .i_clk      (i_clk),
        .i_en       (en[0]),
        .i_u        (i_param_u),
        .i_idx      (i_span_index),
        .i_order    (r_curve_order),
        .i_max_knot (r_max_knot),
        .i_fuzz     (r_fuzz),
        .o_va       (s1_va),
        .o_vb       (s1_vb),
        .o_vc       (s1_vc),
        .o_sa1      (s1_sa1),
        .o_sb1      (s1_sb1),
        .o_sa2      (s1_sa2),
        .o_sb2      (s1_sb2),
        .o_ctl      (s1_ctl)
    );

    bbe_mul u_mul (
        .i_clk (i_clk),
        .i_en2 (en[1]),
        .i_en3 (en[2]),
        .i_va  (s1_va),
        .i_vb  (s1_vb),
        .i_vc  (s1_vc),
        .i_sa1 (s1_sa1),
        .i_sb1 (s1_sb1),
        .i_sa2 (s1_sa2),
        .i_sb2 (s1_sb2),
        .i_ctl (s1_ctl),
        .o_nv  (s3_nv),
        .o_ns  (s3_ns),
        .o_ctl (s3_ctl)
    );

    bbe_round u_round (
        .i_clk (i_clk),
        .i_en4 (en[3]),
        .i_en5 (en[4]),
        .i_nv  (s3_nv),
        .i_ns  (s3_ns),
        .i_ctl (s3_ctl),
        .o_qv  (s5_qv),
        .o_qs  (s5_qs),
        .o_neg (s5_neg)
    );

    // stage 6: sum the terms and saturate
    always_comb begin
        sum_v = '0;
        sum_s = '0;
        for (int i = 0; i < 3; i++) begin
            sum_v = sum_v + SUMW'(s5_qv[i]);
            sum_s = s5_neg[i] ? sum_s - $signed({3'b000, s5_qs[i]})
                              : sum_s + $signed({3'b000, s5_qs[i]});
        end
        n_val = (sum_v > SUMW'(VAL_MAX)) ? VAL_MAX : VW'(sum_v);
        if (sum_s < SSW'(SLOPE_MIN)) begin
            n_slope = SW'(SLOPE_MIN);
        end else if (sum_s > SSW'(SLOPE_MAX)) begin
            n_slope = SW'(SLOPE_MAX);
        end else begin
            n_slope = SW'(sum_s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NST-1]) begin
            r_val   <= n_val;
            r_slope <= n_slope;
        end
    end

    assign o_basis_value = r_val;
    assign o_basis_slope = r_slope;

    // ---------------- assertions ----------------
    a_val_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_basis_value <= VAL_MAX))
        else $error("basis value above 1.0");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted request not held in stage 1");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ((&r_vld) && i_stall))
        else $error("input stalled with room in the pipe");

endmodule

// File: verif/tb_bspline_basis_eval_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_bspline_basis_eval_top
// Self-checking bench for the B-spline basis value and slope evaluator.
// ============================================================================
// Each accepted request goes through a local model of the clamped-knot basis
// math. The result is queued, and every result that leaves the block is
// compared with the oldest queued one. Requests are sent in bursts with
// random gaps, and the output side stalls in a pattern of its own, with one
// long hold-off that fills the pipe. Several register settings are covered,
// the extremes among them, and a few requests go out under each order.
// ============================================================================

class basis_scoreboard;
    typedef struct {
        logic [16:0] val;
        logic [18:0] slope;
    } t_basis_res;

    t_basis_res pending[$];
    int unsigned errors;
    bit [2:0] order;
    bit [7:0] kmax;
    bit [15:0] fuzz;

    function new();
        errors = 0;
        order = 4;
        kmax = 1;
        fuzz = 0;
    endfunction

    // Round (q*2^s + r)/den to nearest, halves up.
    function automatic longint unsigned rdiv(longint unsigned q, longint unsigned r,
                                             int s, longint unsigned den);
        longint unsigned res, rem;
        if (den == 0) return 0;
        res = q / den;
        rem = q % den;
        if (2 * rem >= den) res++;
        else if (2 * rem + 1 == den && s > 0 && r >= (64'd1 << (s - 1))) res++;
        return res;
    endfunction

    function automatic longint signed_term(longint n, int s, longint den, bit fz);
        longint unsigned mag, v;
        mag = n < 0 ? -n : n;
        if (den <= 0) return 0;
        if (fz && mag < fuzz) return 0;
        v = rdiv(mag >> s, mag & ((64'd1 << s) - 1), s, den);
        return n < 0 ? -longint'(v) : longint'(v);
    endfunction

    function automatic longint cube_term(longint x, longint y, longint z, longint den);
        longint unsigned m, xy, az, bz, p, q, r;
        m = 64'hFFFF;
        if (den <= 0 || x < 0 || y < 0 || z < 0) return 0;
        xy = x * y;
        az = (xy >> 16) * z;
        bz = (xy & m) * z;
        p = az + (bz >> 16);
        q = p >> 16;
        r = ((p & m) << 16) | (bz & m);
        if (q == 0 && r < fuzz) return 0;
        return rdiv(q, r, 32, den);
    endfunction

    function automatic void predict(bit [23:0] pu, bit [8:0] idx_in);
        longint u, idx, mk, k, val, slope, b1, b2, b3;
        longint t[5], e[5], f[5];
        int n, span;
        t_basis_res res;
        u = pu; idx = idx_in; mk = kmax; n = order; span = -1;
        val = 0; slope = 0;
        if (u > (mk << 16)) u = mk << 16;
        if (n >= 2 && n <= 4) begin
            for (int j = 0; j <= n; j++) begin
                k = idx - n + j;
                t[j] = k < 0 ? 0 : (k > mk ? mk : k);
                e[j] = u - (t[j] << 16);
                f[j] = -e[j];
            end
            for (int j = 0; j < n && span < 0; j++)
                if (e[j] >= 0 && f[j+1] >= 0 && t[j] != t[j+1]) span = j;
        end
        if (n == 4) begin
            case (span)
                0: begin
                    b1 = (t[3]-t[0]) * (t[2]-t[0]) * (t[1]-t[0]);
                    val = cube_term(e[0], e[0], e[0], b1);
                    slope = signed_term(3 * e[0] * e[0], 16, b1, 1);
                end
                1: begin
                    b1 = (t[3]-t[0]) * (t[2]-t[0]) * (t[2]-t[1]);
                    b2 = (t[3]-t[0]) * (t[3]-t[1]) * (t[2]-t[1]);
                    b3 = (t[4]-t[1]) * (t[3]-t[1]) * (t[2]-t[1]);
                    val = cube_term(e[0], e[0], f[2], b1) + cube_term(e[0], f[3], e[1], b2)
                        + cube_term(f[4], e[1], e[1], b3);
                    slope = signed_term(2*e[0]*f[2] - e[0]*e[0], 16, b1, 1)
                          + signed_term(e[0]*f[3] - e[1]*e[0] + f[3]*e[1], 16, b2, 1)
                          + signed_term(2*f[4]*e[1] - e[1]*e[1], 16, b3, 1);
                end
                2: begin
                    b1 = (t[3]-t[0]) * (t[3]-t[1]) * (t[3]-t[2]);
                    b2 = (t[4]-t[1]) * (t[3]-t[1]) * (t[3]-t[2]);
                    b3 = (t[4]-t[1]) * (t[4]-t[2]) * (t[3]-t[2]);
                    val = cube_term(e[0], f[3], f[3], b1) + cube_term(f[4], e[1], f[3], b2)
                        + cube_term(f[4], f[4], e[2], b3);
                    slope = signed_term(f[3]*f[3] - 2*e[0]*f[3], 16, b1, 1)
                          + signed_term(f[4]*f[3] - f[4]*e[1] - e[1]*f[3], 16, b2, 1)
                          + signed_term(f[4]*f[4] - 2*f[4]*e[2], 16, b3, 1);
                end
                3: begin
                    b1 = (t[4]-t[1]) * (t[4]-t[2]) * (t[4]-t[3]);
                    val = cube_term(f[4], f[4], f[4], b1);
                    slope = signed_term(-3 * f[4] * f[4], 16, b1, 1);
                end
                default: ;
            endcase
        end else if (n == 3) begin
            case (span)
                0: begin
                    b1 = (t[2]-t[0]) * (t[1]-t[0]);
                    val = signed_term(e[0] * e[0], 16, b1, 1);
                    slope = signed_term(2 * e[0], 0, b1, 1);
                end
                1: begin
                    b1 = (t[2]-t[0]) * (t[2]-t[1]);
                    b2 = (t[3]-t[1]) * (t[2]-t[1]);
                    val = signed_term(e[0] * f[2], 16, b1, 1)
                        + signed_term(f[3] * e[1], 16, b2, 1);
                    slope = signed_term(f[2] - e[0], 0, b1, 1)
                          + signed_term(f[3] - e[1], 0, b2, 1);
                end
                2: begin
                    // last span uses (t3-t1)(t3-t2)
                    b1 = (t[3]-t[1]) * (t[3]-t[2]);
                    val = signed_term(f[3] * f[3], 16, b1, 1);
                    slope = signed_term(-2 * f[3], 0, b1, 1);
                end
                default: ;
            endcase
        end else if (n == 2) begin
            if (span == 0) begin
                val = signed_term(e[0], 0, t[1]-t[0], 1);
                slope = signed_term(65536, 0, t[1]-t[0], 0);
            end else if (span == 1) begin
                val = signed_term(f[2], 0, t[2]-t[1], 1);
                slope = signed_term(-65536, 0, t[2]-t[1], 0);
            end
        end
        if (val < 0) val = 0;
        if (val > 65536) val = 65536;
        if (slope < -262144) slope = -262144;
        if (slope > 262143) slope = 262143;
        res.val = val[16:0];
        res.slope = slope[18:0];
        pending.push_back(res);
    endfunction

    function automatic void check(logic [16:0] val, logic [18:0] slope);
        t_basis_res want;
        if (pending.size() == 0) begin
            $error("result with nothing pending: value %0h slope %0h", val, slope);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (val !== want.val) begin
            $error("basis_value expected %0h actual %0h", want.val, val);
            errors++;
        end
        if (slope !== want.slope) begin
            $error("basis_slope expected %0h actual %0h", want.slope, slope);
            errors++;
        end
    endfunction
endclass

module tb_bspline_basis_eval_top;
    import bbe_pkg::*;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    logic [UW-1:0] i_param_u;
    logic [IW-1:0] i_span_index;
    logic          o_valid;
    logic          i_stall;
    logic [VW-1:0] o_basis_value;
    logic signed [SW-1:0] o_basis_slope;
    logic          psel, penable, pwrite;
    logic [3:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    basis_scoreboard sb;
    bit sink_hold_req;     // asks the sink process for one long hold-off
    int unsigned burst_left;

    bspline_basis_eval_top u_top (.*);

    initial begin
        i_clk = 1'b0;
        sb = new();
    end
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Accepted requests feed the model; accepted results are checked.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) sb.predict(i_param_u, i_span_index);
        if (i_rst_n && o_valid && !i_stall) sb.check(o_basis_value, o_basis_slope);
    end

    // Output side: random stall pattern, quiet stretches, one long hold-off.
    initial begin
        int mode_cnt;
        int mode;
        i_stall = 1'b0;
        mode = 0;
        mode_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req) begin
                i_stall <= 1'b1;
                repeat (60) @(posedge i_clk);
                sink_hold_req = 1'b0;
            end
            if (mode_cnt == 0) begin
                mode = $urandom_range(0, 2);
                mode_cnt = $urandom_range(10, 80);
            end
            mode_cnt--;
            case (mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                default: i_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_ORDER: sb.order = data[2:0];
            REG_MAXK:  sb.kmax = data[7:0];
            default:   sb.fuzz = data[15:0];
        endcase
        @(posedge i_clk);
    endtask

    // One request, with the sender's burst and gap pattern in front of it.
    task automatic send_req(input logic [UW-1:0] pu, input logic [IW-1:0] idx);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_param_u <= pu;
        i_span_index <= idx;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        int guard;
        i_valid <= 1'b0;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
    endtask

    // u biased near knots and mostly inside the clamped knot range.
    task automatic random_req();
        logic [UW-1:0] pu;
        logic [IW-1:0] idx;
        int sel;
        sel = $urandom_range(0, 9);
        idx = (sel < 8) ? IW'($urandom_range(0, sb.kmax + 5)) : IW'($urandom);
        if (sel < 6) begin
            pu = {8'($urandom_range(0, sb.kmax)), 16'($urandom)};
            if ($urandom_range(0, 5) == 0) pu[15:0] = $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'h0;
        end else begin
            pu = $urandom;
        end
        send_req(pu, idx);
    endtask

    initial begin
        int total;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_param_u = '0;
        i_span_index = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr = '0; pwdata = '0;
        sink_hold_req = 1'b0;
        burst_left = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, then each order including invalid ones.
        send_req('0, '0);
        send_req(24'hFFFFFF, 9'h1FF);
        send_req(24'h008000, 9'd2);
        drain();
        reg_write(REG_MAXK, 32'd5);
        for (int o = 0; o < 8; o++) begin
            drain();
            reg_write(REG_ORDER, o);
            send_req(24'h018000, 9'(o + 1));
            send_req(24'h020000, 9'(o + 2));
            send_req(24'h050000, 9'(5 + o));
        end
        drain();
        reg_write(REG_FUZZ, 32'hFFFF);
        send_req(24'h000001, 9'd4);
        send_req(24'h02FFFF, 9'd6);
        drain();

        // Random phases over several register settings, extremes included.
        total = 0;
        for (int ph = 0; ph < 12; ph++) begin
            reg_write(REG_ORDER, ph < 9 ? 2 + (ph % 3) : $urandom_range(0, 7));
            case (ph % 4)
                0: reg_write(REG_MAXK, 255);
                1: reg_write(REG_MAXK, 1);
                default: reg_write(REG_MAXK, $urandom_range(2, 40));
            endcase
            case (ph % 3)
                0: reg_write(REG_FUZZ, 0);
                1: reg_write(REG_FUZZ, $urandom_range(0, 3) == 0 ? 65535 : $urandom_range(1, 4000));
                default: reg_write(REG_FUZZ, $urandom_range(0, 65535));
            endcase
            if (ph == 3) sink_hold_req = 1'b1;
            repeat (155) begin
                random_req();
                total++;
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end
endmodule
